[rtl/core/wpas_pkg.sv]
// Shared types, constants and step planning function for the waypoint agent step unit.
`default_nettype none

package wpas_pkg;

    // Ring geometry
    localparam int WAYPOINT_SLOTS = 16;
    localparam int SLOT_W         = (WAYPOINT_SLOTS > 1) ? $clog2(WAYPOINT_SLOTS) : 1;
    localparam int COUNT_W        = $clog2(WAYPOINT_SLOTS + 1);

    localparam logic [COUNT_W-1:0] SLOTS_COUNT = COUNT_W'(WAYPOINT_SLOTS);
    localparam logic [COUNT_W:0]   SLOTS_SUM   = (COUNT_W + 1)'(WAYPOINT_SLOTS);
    localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(WAYPOINT_SLOTS - 1);

    // Command codes; code 3 is unused and leaves the state alone
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_PLACE = 2'd2
    } cmd_t;

    // One waypoint: position, arrival radius, valid flag
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        r;
        logic               valid;
    } wp_entry_t;

    // Outcome of testing and stepping toward one candidate destination
    typedef struct packed {
        logic               reached;
        logic               moved;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } wp_plan_t;

    // Arrival test and rounded unit step toward destination d from (ax, ay)
    function automatic wp_plan_t wp_plan(
        input wp_entry_t          d,
        input logic signed [15:0] ax,
        input logic signed [15:0] ay
    );
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [15:0]        adx;
        logic [15:0]        ady;
        logic [31:0]        dx2;
        logic [31:0]        dy2;
        logic [31:0]        r2;
        logic [32:0]        dist2;
        logic [33:0]        dx2_3;
        logic [33:0]        dy2_3;
        logic               step_x;
        logic               step_y;
        wp_plan_t           p;

        dx    = $signed({d.x[15], d.x}) - $signed({ax[15], ax});
        dy    = $signed({d.y[15], d.y}) - $signed({ay[15], ay});
        adx   = dx[16] ? 16'(-dx) : dx[15:0];
        ady   = dy[16] ? 16'(-dy) : dy[15:0];
        dx2   = 32'(adx) * 32'(adx);
        dy2   = 32'(ady) * 32'(ady);
        r2    = 32'(d.r) * 32'(d.r);
        dist2 = 33'(dx2) + 33'(dy2);
        dx2_3 = {1'b0, dx2, 1'b0} + 34'(dx2);
        dy2_3 = {1'b0, dy2, 1'b0} + 34'(dy2);

        // Step an axis when 3*d^2 exceeds the other axis squared
        step_x = d.valid && (dx2_3 > 34'(dy2));
        step_y = d.valid && (dy2_3 > 34'(dx2));

        p.reached = d.valid && (dist2 < 33'(r2));
        p.moved   = step_x || step_y;
        p.x       = step_x ? (dx[16] ? ax - 16'sd1 : ax + 16'sd1) : ax;
        p.y       = step_y ? (dy[16] ? ay - 16'sd1 : ay + 16'sd1) : ay;
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/waypoint_agent_step_unit.sv]
// Top level: waypoint ring, agent position and command execution.
// A command passes through the input register and then the result register, which res_ready can stall.
// Throughput: one command per cycle while res_ready does not stall; the whole tick (arrival test
// for the current and the front waypoint, both steps) is one pass of logic between the input and
// result registers. Reset (rst_n low, asynchronous): agent at origin, no destination, empty ring;
// the ring entries themselves are not cleared, only entries inside the fill count are ever read.
`default_nettype none

module waypoint_agent_step_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic [1:0]         command,
    input  wire logic signed [15:0] coord_x,
    input  wire logic signed [15:0] coord_y,
    input  wire logic [15:0]        radius,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic                    moved,
    output logic                    status
);

    // Input stage
    logic                  in_valid_reg;
    logic [1:0]            in_cmd_reg;
    logic signed [15:0]    in_x_reg;
    logic signed [15:0]    in_y_reg;
    logic [15:0]           in_r_reg;

    // Result stage
    logic                  res_valid_reg;
    logic                  moved_reg;
    logic                  status_reg;

    // Block state
    logic signed [15:0]    agent_x_reg;
    logic signed [15:0]    agent_y_reg;
    wpas_pkg::wp_entry_t   dest_reg;
    wpas_pkg::wp_entry_t   ring_reg [wpas_pkg::WAYPOINT_SLOTS];
    logic [wpas_pkg::SLOT_W-1:0]  head_reg;
    logic [wpas_pkg::COUNT_W-1:0] count_reg;

    // Next values
    logic signed [15:0]    agent_x_next;
    logic signed [15:0]    agent_y_next;
    wpas_pkg::wp_entry_t   dest_next;
    logic [wpas_pkg::SLOT_W-1:0]  head_next;
    logic [wpas_pkg::COUNT_W-1:0] count_next;
    logic                  moved_next;
    logic                  status_next;

    logic                  ring_we;
    wpas_pkg::wp_entry_t   ring_wdata;

    logic                  advance;
    logic                  in_take;
    wpas_pkg::wp_entry_t   front;
    wpas_pkg::wp_plan_t    plan_cur;
    wpas_pkg::wp_plan_t    plan_front;
    logic                  rotate;
    logic                  ring_full;
    logic [wpas_pkg::COUNT_W:0]   tail_sum;
    logic [wpas_pkg::SLOT_W-1:0]  tail;
    logic [wpas_pkg::SLOT_W-1:0]  head_inc;

    // Handshake: the input stage drains whenever the result stage is free or being taken
    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;
    assign in_take   = cmd_valid && cmd_ready;

    assign res_valid = res_valid_reg;
    assign pos_x     = agent_x_reg;
    assign pos_y     = agent_y_reg;
    assign moved     = moved_reg;
    assign status    = status_reg;

    // Ring pointers: tail = (head + count) mod slots, head wraps at the last slot
    assign tail_sum  = {1'b0, (wpas_pkg::COUNT_W)'(head_reg)} + {1'b0, count_reg};
    assign tail      = (tail_sum >= wpas_pkg::SLOTS_SUM)
                       ? wpas_pkg::SLOT_W'(tail_sum - wpas_pkg::SLOTS_SUM)
                       : wpas_pkg::SLOT_W'(tail_sum);
    assign head_inc  = (head_reg == wpas_pkg::SLOT_LAST) ? '0 : head_reg + 1'b1;
    assign ring_full = (count_reg == wpas_pkg::SLOTS_COUNT);

    // Evaluate the current destination and the front waypoint side by side
    assign front      = ring_reg[head_reg];
    assign plan_cur   = wpas_pkg::wp_plan(dest_reg, agent_x_reg, agent_y_reg);
    assign plan_front = wpas_pkg::wp_plan(front, agent_x_reg, agent_y_reg);
    assign rotate     = (plan_cur.reached || !dest_reg.valid) && (count_reg != '0);

    // Command decode
    always_comb
    begin
        agent_x_next = agent_x_reg;
        agent_y_next = agent_y_reg;
        dest_next    = dest_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        moved_next   = 1'b0;
        status_next  = 1'b0;
        ring_we      = 1'b0;
        ring_wdata   = dest_reg;

        unique case (in_cmd_reg)
            wpas_pkg::CMD_TICK:
            begin
                if (rotate)
                begin
                    ring_we      = 1'b1;
                    ring_wdata   = dest_reg;
                    head_next    = head_inc;
                    dest_next    = front;
                    agent_x_next = plan_front.x;
                    agent_y_next = plan_front.y;
                    moved_next   = plan_front.moved;
                end
                else
                begin
                    agent_x_next = plan_cur.x;
                    agent_y_next = plan_cur.y;
                    moved_next   = plan_cur.moved;
                end
            end
            wpas_pkg::CMD_ADD:
            begin
                if (ring_full)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    ring_we          = 1'b1;
                    ring_wdata.x     = in_x_reg;
                    ring_wdata.y     = in_y_reg;
                    ring_wdata.r     = in_r_reg;
                    ring_wdata.valid = 1'b1;
                    count_next       = count_reg + 1'b1;
                end
            end
            wpas_pkg::CMD_PLACE:
            begin
                agent_x_next = in_x_reg;
                agent_y_next = in_y_reg;
            end
            default:
            begin
                // unused code: hold everything
            end
        endcase
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg <= command;
            in_x_reg   <= coord_x;
            in_y_reg   <= coord_y;
            in_r_reg   <= radius;
        end
    end

    // Result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result flags
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            moved_reg  <= moved_next;
            status_reg <= status_next;
        end
    end

    // Agent, destination and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agent_x_reg <= '0;
            agent_y_reg <= '0;
            dest_reg    <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
        end
        else if (advance)
        begin
            agent_x_reg <= agent_x_next;
            agent_y_reg <= agent_y_next;
            dest_reg    <= dest_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
        end
    end

    // Waypoint ring storage
    always_ff @(posedge clk)
    begin
        if (advance && ring_we)
        begin
            ring_reg[tail] <= ring_wdata;
        end
    end

    // Fill count never passes the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wpas_pkg::SLOTS_COUNT)
        else $error("waypoint ring count out of range");

    // Only an add changes the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg != wpas_pkg::CMD_ADD)) |=> $stable(count_reg))
        else $error("ring count changed without an add");

    // A dropped add only happens on a full ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next) |-> ring_full)
        else $error("add dropped while ring had room");

    // A reported move really changes the position
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && moved_next) |=>
            ((agent_x_reg != $past(agent_x_reg)) || (agent_y_reg != $past(agent_y_reg))))
        else $error("move flagged without a position change");

endmodule

`default_nettype wire

[tb/sv/agent_track_pkg.sv]
`timescale 1ns / 100ps
// Agent track predictor: agent position, destination, waypoint ring and expected result beats.
package agent_track_pkg;
    import wpas_pkg::*;

    // Command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               moved;
        logic               status;
    } agent_step_t;

    class agent_track;
        logic signed [15:0] agent_x;
        logic signed [15:0] agent_y;
        wp_entry_t          dest;
        wp_entry_t          ring [WAYPOINT_SLOTS];
        int unsigned        head;
        int unsigned        count;
        agent_step_t        expected_steps [$];
        int                 mismatches;

        function new();
            agent_x    = '0;
            agent_y    = '0;
            dest       = '0;
            head       = 0;
            count      = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        // Rotate the ring when there is no destination or the agent is inside its radius
        function void refresh_dest();
            longint      dx;
            longint      dy;
            bit          reached;
            wp_entry_t   front;
            int unsigned tail;

            reached = 1'b0;
            if (dest.valid)
            begin
                dx      = longint'($signed(dest.x)) - longint'(agent_x);
                dy      = longint'($signed(dest.y)) - longint'(agent_y);
                reached = (dx * dx + dy * dy) < (longint'(dest.r) * longint'(dest.r));
            end
            if ((reached || !dest.valid) && count > 0)
            begin
                front      = ring[head];
                tail       = (head + count) % WAYPOINT_SLOTS;
                ring[tail] = dest;
                head       = (head + 1) % WAYPOINT_SLOTS;
                dest       = front;
            end
        endfunction

        // Apply one accepted command beat and queue the result it must produce
        function void accept_command(input logic [1:0] cmd, input logic signed [15:0] cx,
                                     input logic signed [15:0] cy, input logic [15:0] rad);
            longint      dx;
            longint      dy;
            int          sx;
            int          sy;
            int unsigned tail;
            agent_step_t res;

            res.moved  = 1'b0;
            res.status = 1'b0;
            case (cmd)
                CMD_TICK:
                begin
                    refresh_dest();
                    if (dest.valid)
                    begin
                        dx = longint'($signed(dest.x)) - longint'(agent_x);
                        dy = longint'($signed(dest.y)) - longint'(agent_y);
                        // Step an axis when three times its square beats the other square
                        sx = (3 * dx * dx > dy * dy) ? ((dx > 0) ? 1 : -1) : 0;
                        sy = (3 * dy * dy > dx * dx) ? ((dy > 0) ? 1 : -1) : 0;
                        agent_x   = agent_x + 16'(sx);
                        agent_y   = agent_y + 16'(sy);
                        res.moved = (sx != 0) || (sy != 0);
                    end
                end
                CMD_ADD:
                begin
                    if (count >= WAYPOINT_SLOTS)
                        res.status = 1'b1;
                    else
                    begin
                        tail       = (head + count) % WAYPOINT_SLOTS;
                        ring[tail] = '{x: cx, y: cy, r: rad, valid: 1'b1};
                        count++;
                    end
                end
                CMD_PLACE:
                begin
                    agent_x = cx;
                    agent_y = cy;
                end
                default:
                begin
                end
            endcase
            res.pos_x = agent_x;
            res.pos_y = agent_y;
            expected_steps.insert(expected_steps.size(), res);
        endfunction

        // Compare one result beat with the oldest expectation
        function void match_step(input logic signed [15:0] px, input logic signed [15:0] py,
                                 input logic mv, input logic st);
            agent_step_t want;

            if (expected_steps.size() == 0)
            begin
                $error("unexpected result beat: pos_x %0d pos_y %0d moved %0b status %0b",
                       px, py, mv, st);
                mismatches++;
                return;
            end
            want = expected_steps[0];
            expected_steps.delete(0);
            if (px !== want.pos_x)
            begin
                $error("pos_x: expected %0d, actual %0d", want.pos_x, px);
                mismatches++;
            end
            if (py !== want.pos_y)
            begin
                $error("pos_y: expected %0d, actual %0d", want.pos_y, py);
                mismatches++;
            end
            if (mv !== want.moved)
            begin
                $error("moved: expected %0b, actual %0b", want.moved, mv);
                mismatches++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0b, actual %0b", want.status, st);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[tb/sv/tb_waypoint_agent_step_unit.sv]
`timescale 1ns / 100ps
// Testbench top: drives command beats, collects result beats and checks them.
module tb_waypoint_agent_step_unit;
    import wpas_pkg::*;
    import agent_track_pkg::*;

    localparam int RANDOM_ITEMS   = 1275;
    localparam int ADD_CAP        = WAYPOINT_SLOTS - 2;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 250000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    logic [1:0]         command   = '0;
    logic signed [15:0] coord_x   = '0;
    logic signed [15:0] coord_y   = '0;
    logic [15:0]        radius    = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               moved;
    logic               status;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        holdoff_req   = 1'b0;
    logic        holdoff_done  = 1'b0;
    int          holdoff_left  = 0;
    int          cycle_count   = 0;
    int          beats_sent    = 0;
    agent_track  track;

    waypoint_agent_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .radius    (radius),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .moved     (moved),
        .status    (status)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("waypoint_agent_step_unit regression: fail");
            $finish;
        end
    end

    // Count down the one long receiver hold-off once it is requested
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoff_req && !holdoff_done)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end
    end

    // Check each result beat; drive result backpressure, held low during the hold-off
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            track.match_step(pos_x, pos_y, moved, status);
        if ((holdoff_left > 0) || (holdoff_req && !holdoff_done))
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one command beat and hold it until accepted
    task automatic send_cmd(input logic [1:0] cmd, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [15:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= cmd;
        coord_x   <= x;
        coord_y   <= y;
        radius    <= r;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        track.accept_command(cmd, x, y, r);
        beats_sent++;
    endtask

    function automatic logic signed [15:0] near_origin(input int span);
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [15:0] any16();
        return 16'($urandom);
    endfunction

    // Mostly tight radii so the agent arrives, now and then a wide one
    function automatic logic [15:0] pick_radius();
        int roll;

        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(10, 1));
        else if (roll < 90)
            return 16'($urandom_range(200, 11));
        return 16'($urandom_range(65535, 201));
    endfunction

    // Add near the origin below the cap, tick from the cap until full, add anything once full
    task automatic offer_add(input int cap);
        if (track.count >= WAYPOINT_SLOTS)
            send_cmd(CMD_ADD, any16(), any16(), any16());
        else if (track.count < cap)
            send_cmd(CMD_ADD, near_origin(40), near_origin(40), pick_radius());
        else
            send_cmd(CMD_TICK, any16(), any16(), any16());
    endtask

    // Mostly walks: place the agent near the waypoints and tick; the rest single random beats
    task automatic run_random(input int n, input int cap);
        int target;
        int steps;
        int i;
        int roll;
        int cmd;

        target = beats_sent + n;
        while (beats_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                send_cmd(CMD_PLACE, near_origin(60), near_origin(60), any16());
                steps = $urandom_range(40, 5);
                for (i = 0; i < steps; i++)
                begin
                    if ($urandom_range(9) == 0)
                        offer_add(cap);
                    else
                        send_cmd(CMD_TICK, any16(), any16(), any16());
                end
            end
            else
            begin
                cmd = $urandom_range(3);
                if (cmd == CMD_ADD)
                    offer_add(cap);
                else
                    send_cmd(2'(cmd), any16(), any16(), any16());
            end
        end
    endtask

    initial
    begin
        int i;

        track = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        stall_pct     = 58;

        // Empty ring and no destination: hold still; unused code changes nothing
        send_cmd(CMD_TICK, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_cmd(CMD_UNUSED, 16'h8000, 16'h7FFF, 16'h0000);
        // Extreme placements, then the widest possible step distance
        send_cmd(CMD_PLACE, 16'h7FFF, 16'h8000, 16'h0000);
        send_cmd(CMD_PLACE, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_cmd(CMD_ADD, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(CMD_ADD, 16'h8000, 16'h8000, 16'hFFFF);
        // Agent sits on its destination: zero distance, no move; then a diagonal run
        send_cmd(CMD_PLACE, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
        // Short walks around the origin through the ring
        send_cmd(CMD_PLACE, 16'h0000, 16'h0000, 16'h5555);
        send_cmd(CMD_ADD, 16'sd3, -16'sd2, 16'd1);
        send_cmd(CMD_ADD, -16'sd5, 16'sd7, 16'd2);
        send_cmd(CMD_ADD, 16'sd0, 16'sd0, 16'hAAAA);
        for (i = 0; i < 7; i++)
            send_cmd(CMD_TICK, any16(), any16(), any16());
        send_cmd(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000);

        run_random(RANDOM_ITEMS / 3, ADD_CAP);

        send_idle_pct = 58;
        stall_pct     = 20;
        run_random(RANDOM_ITEMS / 3, ADD_CAP);

        // No idling; the receiver holds off once so the block backs up
        send_idle_pct = 0;
        stall_pct     = 0;
        holdoff_req  <= 1'b1;
        run_random(RANDOM_ITEMS / 3, WAYPOINT_SLOTS);

        // Fill the ring, last slot with a zero radius, then drop adds on the full ring
        while (track.count < WAYPOINT_SLOTS - 1)
            send_cmd(CMD_ADD, near_origin(40), near_origin(40), pick_radius());
        if (track.count < WAYPOINT_SLOTS)
            send_cmd(CMD_ADD, near_origin(20), near_origin(20), 16'h0000);
        send_cmd(CMD_ADD, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_cmd(CMD_ADD, 16'h8000, 16'h7FFF, 16'h0000);
        send_cmd(CMD_PLACE, near_origin(30), near_origin(30), any16());
        for (i = 0; i < 30; i++)
            send_cmd(CMD_TICK, any16(), any16(), any16());
        cmd_valid <= 1'b0;

        // Drain, then wait for stray beats
        while (track.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (track.mismatches == 0)
            $display("waypoint_agent_step_unit regression: pass");
        else
            $display("waypoint_agent_step_unit regression: fail");
        $finish;
    end

endmodule
